FILE: src/tlfd_pkg.sv
// Shared types, constants and the CRC-32 byte update for the tagged frame deframer.
`timescale 1ns / 1ps

package tlfd_pkg;

	localparam int MAX_FRAME_BYTES = 2048;
	localparam int HEADER_BYTES    = 12;
	localparam int INDEX_LIMIT     = 2048;
	localparam int MIN_FRAME_LEN   = HEADER_BYTES + 4;
	localparam int LEN_CAP         = (MAX_FRAME_BYTES < INDEX_LIMIT) ? MAX_FRAME_BYTES
	                                                                : INDEX_LIMIT;

	// queue depths must be powers of two: pointers wrap by overflow
	localparam int CMD_DEPTH = 4;
	localparam int CMD_AW    = $clog2(CMD_DEPTH);
	localparam int RES_DEPTH = 4;
	localparam int RES_AW    = $clog2(RES_DEPTH);

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	localparam logic [15:0] SYNC_TAG_RST = 16'h0000;
	localparam logic [11:0] MAX_LEN_RST  = 12'd2048;

	typedef enum logic {
		REG_SYNC_TAG = 1'b0,
		REG_MAX_LEN  = 1'b1
	} reg_idx_t;

	typedef enum logic {
		CMD_DATA      = 1'b0,
		CMD_LINK_LOST = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} cmd_t;

	typedef enum logic [1:0] {
		PH_HUNT1  = 2'd0,
		PH_HUNT2  = 2'd1,
		PH_HEADER = 2'd2,
		PH_BODY   = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [10:0] byte_index;
		logic        last;
		logic        crc_ok;
		logic        frame_error;
		logic        aborted;
	} res_t;

	typedef struct packed {
		logic vld0;
		logic vld1;
		res_t r0;
		res_t r1;
	} res_push_t;

	typedef struct packed {
		logic [15:0] sync_tag;
		logic [11:0] max_len;
	} cfg_t;

	function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

FILE: src/tlfd_front.sv
// Front end: accepts input words, classifies them and queues commands for the framer.
`timescale 1ns / 1ps

module tlfd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic          req_type,
	input  logic [7:0]    data_byte,
	output logic          cmd_vld,
	output tlfd_pkg::cmd_t cmd,
	input  logic          cmd_pop
);
	import tlfd_pkg::*;

	cmd_t              mem_q [CMD_DEPTH];
	logic [CMD_AW-1:0] wp_q;
	logic [CMD_AW-1:0] rp_q;
	logic [CMD_AW:0]   cnt_q;
	logic              wr;
	logic              rd;
	cmd_t              cmd_in;

	assign full    = (cnt_q == (CMD_AW + 1)'(CMD_DEPTH));
	assign cmd_vld = (cnt_q != '0);
	assign wr      = push && !full;
	assign rd      = cmd_pop && cmd_vld;

	always_comb begin
		cmd_in.kind = req_type ? CMD_LINK_LOST : CMD_DATA;
		// payload of a link-lost word is never used
		cmd_in.data = req_type ? 8'h00 : data_byte;
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= cmd_in;
		end
	end

	assign cmd = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (CMD_AW + 1)'(wr) - (CMD_AW + 1)'(rd);
		end
	end

endmodule

FILE: src/tlfd_back.sv
// Back end: sync hunt, header parse, body pass-through and CRC-32 check.
`timescale 1ns / 1ps

module tlfd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  tlfd_pkg::cfg_t     cfg,
	input  logic               cmd_vld,
	input  tlfd_pkg::cmd_t     cmd,
	output logic               cmd_pop,
	input  logic               res_room,
	output tlfd_pkg::res_push_t res_push
);
	import tlfd_pkg::*;

	localparam logic [10:0] HDR_LEN_HI = 11'(HEADER_BYTES - 2);
	localparam logic [10:0] HDR_LEN_LO = 11'(HEADER_BYTES - 1);
	localparam logic [15:0] MIN_LEN    = 16'(MIN_FRAME_LEN);
	localparam logic [11:0] CAP        = 12'(LEN_CAP);

	phase_t      phase_q, phase_d;
	logic [10:0] cnt_q, cnt_d;
	logic [15:0] len_q, len_d;
	logic [31:0] crc_q, crc_d;
	logic [31:0] trl_q, trl_d;

	logic        take;
	logic        lost;
	logic [7:0]  b;
	logic [7:0]  tag_hi;
	logic [7:0]  tag_lo;
	logic [11:0] lim;
	logic [15:0] len_fin;
	logic        hdr_end;
	logic        len_bad;
	logic        body_end;
	logic        in_crc;
	logic [31:0] crc_in;
	logic [31:0] crc_nx;
	logic [31:0] trl_sh;
	res_t        r0;
	res_t        r1;

	assign take    = cmd_vld && res_room;
	assign cmd_pop = take;
	assign lost    = (cmd.kind == CMD_LINK_LOST);
	assign b       = cmd.data;
	assign tag_hi  = cfg.sync_tag[15:8];
	assign tag_lo  = cfg.sync_tag[7:0];
	assign lim     = (cfg.max_len > CAP) ? CAP : cfg.max_len;
	assign len_fin = {len_q[15:8], b};
	assign hdr_end = (cnt_q == HDR_LEN_LO);
	assign len_bad = (len_fin < MIN_LEN) || (len_fin > {4'h0, lim});
	assign body_end = (({6'h0, cnt_q} + 17'd1) >= {1'b0, len_q});
	assign in_crc   = (({6'h0, cnt_q} + 17'd4) < {1'b0, len_q});
	// seed the second tag byte step from the first tag byte of the live tag register
	assign crc_in  = (phase_q == PH_HUNT2) ? crc_byte(CRC_INIT, tag_hi) : crc_q;
	assign crc_nx  = crc_byte(crc_in, b);
	assign trl_sh  = {trl_q[23:0], b};

	always_comb begin
		phase_d = phase_q;
		if (take) begin
			if (lost) begin
				phase_d = PH_HUNT1;
			end else begin
				case (phase_q)
					PH_HUNT1: begin
						if (b == tag_hi) begin
							phase_d = PH_HUNT2;
						end
					end
					PH_HUNT2: begin
						phase_d = (b == tag_lo) ? PH_HEADER : PH_HUNT1;
					end
					PH_HEADER: begin
						if (hdr_end) begin
							phase_d = len_bad ? PH_HUNT1 : PH_BODY;
						end
					end
					PH_BODY: begin
						if (body_end) begin
							phase_d = PH_HUNT1;
						end
					end
					default: phase_d = PH_HUNT1;
				endcase
			end
		end
	end

	always_comb begin
		cnt_d = cnt_q;
		len_d = len_q;
		crc_d = crc_q;
		trl_d = trl_q;
		r0    = '0;
		r1    = '0;
		res_push.vld0 = 1'b0;
		res_push.vld1 = 1'b0;
		if (take) begin
			if (lost) begin
				if (phase_q == PH_HEADER || phase_q == PH_BODY) begin
					r0.byte_index = cnt_q;
					r0.last       = 1'b1;
					r0.aborted    = 1'b1;
					res_push.vld0 = 1'b1;
				end
				cnt_d = '0;
				len_d = '0;
				crc_d = CRC_INIT;
				trl_d = '0;
			end else begin
				case (phase_q)
					PH_HUNT1: begin
						// only the phase moves while hunting
					end
					PH_HUNT2: begin
						if (b == tag_lo) begin
							crc_d = crc_nx;
							cnt_d = 11'd2;
							r0.out_byte   = tag_hi;
							r0.byte_index = 11'd0;
							r1.out_byte   = tag_lo;
							r1.byte_index = 11'd1;
							res_push.vld0 = 1'b1;
							res_push.vld1 = 1'b1;
						end else begin
							crc_d = CRC_INIT;
							cnt_d = '0;
						end
						len_d = '0;
						trl_d = '0;
					end
					PH_HEADER: begin
						crc_d = crc_nx;
						cnt_d = cnt_q + 11'd1;
						r0.out_byte   = b;
						r0.byte_index = cnt_q;
						res_push.vld0 = 1'b1;
						if (cnt_q == HDR_LEN_HI) begin
							len_d = {b, 8'h00};
						end
						if (hdr_end) begin
							len_d = len_fin;
							if (len_bad) begin
								// reject: flag the length byte and resume the hunt
								r0.last        = 1'b1;
								r0.frame_error = 1'b1;
								cnt_d = '0;
								len_d = '0;
								crc_d = CRC_INIT;
								trl_d = '0;
							end
						end
					end
					PH_BODY: begin
						if (in_crc) begin
							crc_d = crc_nx;
						end else begin
							trl_d = trl_sh;
						end
						cnt_d = cnt_q + 11'd1;
						r0.out_byte   = b;
						r0.byte_index = cnt_q;
						res_push.vld0 = 1'b1;
						if (body_end) begin
							r0.last   = 1'b1;
							r0.crc_ok = (~crc_q == (in_crc ? trl_q : trl_sh));
							cnt_d = '0;
							len_d = '0;
							crc_d = CRC_INIT;
							trl_d = '0;
						end
					end
					default: begin
						cnt_d = '0;
					end
				endcase
			end
		end
		res_push.r0 = r0;
		res_push.r1 = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
			cnt_q   <= '0;
			len_q   <= '0;
			crc_q   <= CRC_INIT;
			trl_q   <= '0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			len_q   <= len_d;
			crc_q   <= crc_d;
			trl_q   <= trl_d;
		end
	end

endmodule

FILE: src/tlfd_res_queue.sv
// Result queue: takes up to two result words a cycle, hands out one word a cycle.
`timescale 1ns / 1ps

module tlfd_res_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  tlfd_pkg::res_push_t res_push,
	output logic               res_room,
	output logic               empty,
	input  logic               pop,
	output tlfd_pkg::res_t     head
);
	import tlfd_pkg::*;

	res_t              mem_q [RES_DEPTH];
	logic [RES_AW-1:0] wp_q;
	logic [RES_AW-1:0] rp_q;
	logic [RES_AW:0]   cnt_q;
	logic              rd;
	logic [RES_AW-1:0] wp_nx;
	logic [RES_AW:0]   n_wr;

	assign empty    = (cnt_q == '0);
	// room for a full tag pair, whatever the consumer does this cycle
	assign res_room = (cnt_q <= (RES_AW + 1)'(RES_DEPTH - 2));
	assign rd       = pop && !empty;
	assign wp_nx    = wp_q + 1'b1;
	assign n_wr     = (RES_AW + 1)'(res_push.vld0) + (RES_AW + 1)'(res_push.vld1);
	assign head     = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (res_push.vld0) begin
			mem_q[wp_q] <= res_push.r0;
		end
		if (res_push.vld1) begin
			mem_q[wp_nx] <= res_push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + RES_AW'(n_wr);
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + n_wr - (RES_AW + 1)'(rd);
		end
	end

endmodule

FILE: src/tagged_length_frame_deframer.sv
// Path: input queue, then the framer (when the result queue has room), then the result queue.
// Throughput: one input word per cycle unless full; a tag pair yields two result words in one
// cycle, absorbed by the four-word result queue, while the framer step (one CRC byte) sets the rate.
// Input and result queues are four words deep each; a stalled consumer backs up into full.
// Reset (arst_n, asynchronous): queues empty, framer hunting, sync_tag = 0, max_frame_len = 2048.
`timescale 1ns / 1ps

module tagged_length_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic        req_type,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic [10:0] byte_index,
	output logic        last,
	output logic        crc_ok,
	output logic        frame_error,
	output logic        aborted
);
	import tlfd_pkg::*;

	cfg_t      cfg_q;
	reg_idx_t  ridx;
	logic      cfg_wr;
	logic      cmd_vld;
	cmd_t      cmd;
	logic      cmd_pop;
	logic      res_room;
	res_push_t res_push;
	res_t      head;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[2]);
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_tag <= SYNC_TAG_RST;
			cfg_q.max_len  <= MAX_LEN_RST;
		end else if (cfg_wr) begin
			case (ridx)
				REG_SYNC_TAG: cfg_q.sync_tag <= pwdata[15:0];
				REG_MAX_LEN:  cfg_q.max_len  <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_SYNC_TAG: prdata = {16'h0, cfg_q.sync_tag};
			REG_MAX_LEN:  prdata = {20'h0, cfg_q.max_len};
			default:      prdata = '0;
		endcase
	end

	tlfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req_type  (req_type),
		.data_byte (data_byte),
		.cmd_vld   (cmd_vld),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	tlfd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd_vld  (cmd_vld),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.res_room (res_room),
		.res_push (res_push)
	);

	tlfd_res_queue u_res_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_room (res_room),
		.empty    (empty),
		.pop      (pop),
		.head     (head)
	);

	assign out_byte    = head.out_byte;
	assign byte_index  = head.byte_index;
	assign last        = head.last;
	assign crc_ok      = head.crc_ok;
	assign frame_error = head.frame_error;
	assign aborted     = head.aborted;

endmodule

FILE: tb/sv/tb_tagged_length_frame_deframer.sv
// Self-checking testbench for the tagged length frame deframer: framed byte streams against a predictor.
`timescale 1ns / 1ps

module tb_tagged_length_frame_deframer;
	import tlfd_pkg::*;

	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 12;
	localparam int NO_CUT       = 65536;
	localparam int PRINT_CAP    = 50;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [2:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        push      = 1'b0;
	logic        full;
	logic        req_type  = 1'b0;
	logic [7:0]  data_byte = '0;
	logic        empty;
	logic        pop       = 1'b0;
	logic [7:0]  out_byte;
	logic [10:0] byte_index;
	logic        last;
	logic        crc_ok;
	logic        frame_error;
	logic        aborted;

	// framer prediction state and register copies
	phase_t      fr_phase;
	logic [10:0] fr_count;
	logic [15:0] fr_len;
	logic [31:0] fr_crc;
	logic [31:0] fr_trail;
	logic [15:0] cfg_tag     = SYNC_TAG_RST;
	logic [11:0] cfg_max_len = MAX_LEN_RST;

	res_t expected_words[$];
	int   errors           = 0;
	int   frame_bytes_sent = 0;
	int   send_idle        = 0;
	int   recv_stall       = 0;
	int   idle_cycles      = 0;
	bit   drain_mid_frame  = 1'b0;

	tagged_length_frame_deframer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.push       (push),
		.full       (full),
		.req_type   (req_type),
		.data_byte  (data_byte),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.byte_index (byte_index),
		.last       (last),
		.crc_ok     (crc_ok),
		.frame_error(frame_error),
		.aborted    (aborted)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// reflected CRC-32, one data bit folded in per shift
	function automatic logic [31:0] crc32_step(logic [31:0] acc, logic [7:0] d);
		logic [31:0] r;
		r = acc;
		for (int k = 0; k < 8; k++) begin
			r = (r >> 1) ^ ((r[0] ^ d[k]) ? CRC_POLY : 32'h0);
		end
		return r;
	endfunction

	function automatic res_t make_word(logic [7:0] b, logic [10:0] idx, logic lst, logic ok,
	                                   logic err, logic ab);
		res_t r;
		r.out_byte    = b;
		r.byte_index  = idx;
		r.last        = lst;
		r.crc_ok      = ok;
		r.frame_error = err;
		r.aborted     = ab;
		return r;
	endfunction

	task automatic restart_hunt();
		fr_phase = PH_HUNT1;
		fr_count = '0;
		fr_len   = '0;
		fr_crc   = CRC_INIT;
		fr_trail = '0;
	endtask

	task automatic predict_word(cmd_kind_t kind, logic [7:0] b);
		logic [7:0] tag_hi;
		logic [7:0] tag_lo;
		int         idx;
		int         lim;
		tag_hi = cfg_tag[15:8];
		tag_lo = cfg_tag[7:0];
		lim    = (cfg_max_len < LEN_CAP) ? cfg_max_len : LEN_CAP;
		idx    = fr_count;
		if (kind == CMD_LINK_LOST) begin
			if (fr_phase == PH_HEADER || fr_phase == PH_BODY)
				expected_words.push_back(make_word(8'h00, fr_count, 1'b1, 1'b0, 1'b0, 1'b1));
			restart_hunt();
			return;
		end
		case (fr_phase)
			PH_HUNT1: begin
				if (b == tag_hi)
					fr_phase = PH_HUNT2;
			end
			PH_HUNT2: begin
				// drop the mismatching byte; it is not retried as a first tag byte
				if (b != tag_lo) begin
					restart_hunt();
				end else begin
					fr_crc   = crc32_step(crc32_step(CRC_INIT, tag_hi), tag_lo);
					fr_trail = '0;
					fr_len   = '0;
					fr_count = 11'd2;
					fr_phase = PH_HEADER;
					expected_words.push_back(make_word(tag_hi, 11'd0, 1'b0, 1'b0, 1'b0, 1'b0));
					expected_words.push_back(make_word(tag_lo, 11'd1, 1'b0, 1'b0, 1'b0, 1'b0));
				end
			end
			PH_HEADER: begin
				fr_crc = crc32_step(fr_crc, b);
				if (idx == HEADER_BYTES - 2)
					fr_len = {b, 8'h00};
				if (idx == HEADER_BYTES - 1) begin
					fr_len[7:0] = b;
					if (fr_len < MIN_FRAME_LEN || fr_len > lim) begin
						expected_words.push_back(make_word(b, 11'(idx), 1'b1, 1'b0, 1'b1,
						                                   1'b0));
						restart_hunt();
						return;
					end
					fr_phase = PH_BODY;
				end
				fr_count = fr_count + 11'd1;
				expected_words.push_back(make_word(b, 11'(idx), 1'b0, 1'b0, 1'b0, 1'b0));
			end
			default: begin
				// last four bytes carry the CRC, most significant first
				if (idx + 4 < fr_len)
					fr_crc = crc32_step(fr_crc, b);
				else
					fr_trail = {fr_trail[23:0], b};
				if (idx + 1 >= fr_len) begin
					expected_words.push_back(make_word(b, 11'(idx), 1'b1,
					                                   (~fr_crc) == fr_trail, 1'b0, 1'b0));
					restart_hunt();
					return;
				end
				fr_count = fr_count + 11'd1;
				expected_words.push_back(make_word(b, 11'(idx), 1'b0, 1'b0, 1'b0, 1'b0));
			end
		endcase
	endtask

	task automatic report_mismatch(string msg);
		if (errors < PRINT_CAP)
			$display("MISMATCH at %0t: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	// result side: compare every accepted word with the oldest prediction
	always @(posedge clk) begin : result_check
		res_t got;
		res_t want;
		if (arst_n && pop && !empty) begin
			got = {out_byte, byte_index, last, crc_ok, frame_error, aborted};
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word byte %02h index %0d",
				                          out_byte, byte_index));
			end else begin
				want = expected_words.pop_front();
				check_field("out_byte", 32'(got.out_byte), 32'(want.out_byte));
				check_field("byte_index", 32'(got.byte_index), 32'(want.byte_index));
				check_field("last", 32'(got.last), 32'(want.last));
				check_field("crc_ok", 32'(got.crc_ok), 32'(want.crc_ok));
				check_field("frame_error", 32'(got.frame_error), 32'(want.frame_error));
				check_field("aborted", 32'(got.aborted), 32'(want.aborted));
			end
		end
	end

	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n || psel) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic send_word(cmd_kind_t kind, logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push      <= 1'b1;
		req_type  <= kind;
		data_byte <= b;
		do @(posedge clk); while (full);
		predict_word(kind, b);
	endtask

	task automatic wait_results_drained();
		push <= 1'b0;
		do @(posedge clk); while (expected_words.size() != 0);
	endtask

	// hold off until results are out and words that yield none have left the pipe
	task automatic settle();
		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(reg_idx_t idx, logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_SYNC_TAG)
			cfg_tag = v[15:0];
		else
			cfg_max_len = v[11:0];
		@(posedge clk);
	endtask

	task automatic configure(logic [15:0] tag, logic [11:0] max_len);
		settle();
		apb_write(REG_SYNC_TAG, {16'h0, tag});
		apb_write(REG_MAX_LEN, {20'h0, max_len});
	endtask

	// send a frame built for the current tag; cut it short with link loss if asked
	task automatic send_frame(logic [15:0] len_field, int stop_after, bit corrupt);
		logic [7:0]  q[$];
		logic [31:0] c;
		int          total;
		int          lim;
		int          pos;
		lim   = (cfg_max_len < LEN_CAP) ? cfg_max_len : LEN_CAP;
		total = (len_field >= MIN_FRAME_LEN && len_field <= lim) ? len_field : HEADER_BYTES;
		q.push_back(cfg_tag[15:8]);
		q.push_back(cfg_tag[7:0]);
		for (int i = 2; i < HEADER_BYTES - 2; i++)
			q.push_back(8'($urandom_range(255)));
		q.push_back(len_field[15:8]);
		q.push_back(len_field[7:0]);
		while (q.size() < total - 4)
			q.push_back(8'($urandom_range(255)));
		if (total > HEADER_BYTES) begin
			c = CRC_INIT;
			foreach (q[i])
				c = crc32_step(c, q[i]);
			c = ~c;
			q.push_back(c[31:24]);
			q.push_back(c[23:16]);
			q.push_back(c[15:8]);
			q.push_back(c[7:0]);
			if (corrupt) begin
				pos    = $urandom_range(total - 1, HEADER_BYTES);
				q[pos] = q[pos] ^ (8'h01 << $urandom_range(7));
			end
		end
		if (stop_after > total)
			stop_after = total;
		for (int i = 0; i < stop_after; i++) begin
			if (drain_mid_frame && i == stop_after / 2)
				wait_results_drained();
			send_word(CMD_DATA, q[i]);
		end
		frame_bytes_sent += stop_after;
		if (stop_after < total)
			send_word(CMD_LINK_LOST, 8'($urandom_range(255)));
	endtask

	task automatic test_tag_hunt();
		send_idle  = 0;
		recv_stall = 0;
		configure(16'hC3A5, 12'd2048);
		// second byte repeats the high tag byte: must not restart the tag
		send_word(CMD_DATA, 8'hC3);
		send_word(CMD_DATA, 8'hC3);
		send_word(CMD_DATA, 8'hA5);
		send_word(CMD_DATA, 8'hC3);
		send_word(CMD_LINK_LOST, 8'hFF);
	endtask

	task automatic test_min_frame();
		send_frame(16'(MIN_FRAME_LEN), NO_CUT, 1'b0);
	endtask

	task automatic test_abort();
		send_frame(16'd32, 3, 1'b0);
	endtask

	task automatic test_length_limits();
		configure(16'h0000, 12'd16);
		send_frame(16'd16, NO_CUT, 1'b0);
		send_frame(16'd17, NO_CUT, 1'b0);
		send_frame(16'd15, NO_CUT, 1'b0);
		send_frame(16'h0000, NO_CUT, 1'b0);
		send_frame(16'hFFFF, NO_CUT, 1'b0);
		configure(16'hFFFF, 12'd64);
		send_frame(16'd64, NO_CUT, 1'b0);
		send_frame(16'd65, NO_CUT, 1'b0);
		send_frame(16'd63, NO_CUT, 1'b1);
		configure(16'hFFFF, 12'd2048);
		send_frame(16'd2049, NO_CUT, 1'b0);
		send_frame(16'hF000, NO_CUT, 1'b0);
	endtask

	task automatic test_drain_pause();
		drain_mid_frame = 1'b1;
		send_frame(16'd40, NO_CUT, 1'b0);
		drain_mid_frame = 1'b0;
	endtask

	// mostly well-formed frames, with corrupt, rejected, cut-off frames and line noise mixed in
	task automatic test_traffic(logic [15:0] tag, logic [11:0] max_len, int s_idle, int r_stall,
	                            int n_items);
		int start;
		int lim;
		int len;
		int pick;
		configure(tag, max_len);
		send_idle  = s_idle;
		recv_stall = r_stall;
		start      = frame_bytes_sent;
		lim        = (cfg_max_len < LEN_CAP) ? cfg_max_len : LEN_CAP;
		while (frame_bytes_sent - start < n_items) begin
			pick = $urandom_range(99);
			if ($urandom_range(19) == 0)
				len = $urandom_range((lim < 256) ? lim : 256, MIN_FRAME_LEN);
			else
				len = $urandom_range((lim < 40) ? lim : 40, MIN_FRAME_LEN);
			if (pick < 55)
				send_frame(16'(len), NO_CUT, 1'b0);
			else if (pick < 65)
				send_frame(16'(len), NO_CUT, 1'b1);
			else if (pick < 77)
				send_frame(16'($urandom_range(1) ? $urandom_range(MIN_FRAME_LEN - 1)
				                                 : $urandom_range(65535, lim + 1)),
				           NO_CUT, 1'b0);
			else if (pick < 90)
				send_frame(16'(len), $urandom_range(len - 1, 1), 1'b0);
			else
				repeat ($urandom_range(6, 1))
					send_word(($urandom_range(3) == 0) ? CMD_LINK_LOST : CMD_DATA,
					          8'($urandom_range(255)));
		end
	endtask

	initial begin
		restart_hunt();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_tag_hunt();
		test_min_frame();
		test_abort();
		test_length_limits();
		test_traffic(16'($urandom_range(16'hFFFF)), 12'd2048, 0, 0, 60);
		test_traffic(16'hFFFF, 12'($urandom_range(2048, 16)), 84, 0, 60);
		test_traffic(16'h0000, 12'd16, 0, 84, 60);
		test_drain_pause();
		test_traffic(16'h7E7E, 12'($urandom_range(2048, 16)), 25, 25, 60);
		settle();
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
